// ===== design/dpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dpr_pkg;

  localparam int COORD_BITS     = 11;
  localparam int COEF_FRAC_BITS = 16;
  localparam int DEPTH_BITS     = 16;
  localparam int DEPTH_LIMIT    = 40000;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int FRAME_W        = 12;
  localparam int SUM_W          = 64;
  localparam int REM_W          = SUM_W + COORD_BITS;
  localparam int DIV_LAT        = COORD_BITS;
  localparam int FRONT_LAT      = 4;
  localparam int TOTAL_LAT      = FRONT_LAT + DIV_LAT + 1;

  localparam logic [FRAME_W-1:0] WIDTH_RESET  = FRAME_W'(1280);
  localparam logic [FRAME_W-1:0] HEIGHT_RESET = FRAME_W'(720);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_X_UV     = 3'd0,
    REG_COEF_X_CB     = 3'd1,
    REG_COEF_Y_UV     = 3'd2,
    REG_COEF_Y_CB     = 3'd3,
    REG_COEF_Z_UV     = 3'd4,
    REG_COEF_Z_CB     = 3'd5,
    REG_FRAME_WIDTH   = 3'd6,
    REG_FRAME_HEIGHT  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_col;
    logic [COORD_BITS-1:0] src_row;
    logic [DEPTH_BITS-1:0] depth_mm;
  } pixel_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] dest_col;
    logic [COORD_BITS-1:0] dest_row;
    logic [DEPTH_BITS-1:0] dest_depth;
    logic                  valid_res;
  } result_t;

  typedef struct packed {
    logic                  vld;
    logic                  ok;
    logic [REM_W-1:0]      rx;
    logic [REM_W-1:0]      ry;
    logic [SUM_W-2:0]      z;
    logic [COORD_BITS-1:0] qx;
    logic [COORD_BITS-1:0] qy;
    logic [DEPTH_BITS-1:0] depth;
  } div_t;

endpackage

`default_nettype wire

// ===== design/depth_pixel_reprojection.sv =====
// throughput: one pixel per clock, busy is never raised
// front end: products, row sums, depth multiply, offset add (4 stages)
// then an 11-stage restoring divider for column and row, then the output register
// synchronous reset clears the valid pipe and loads the default register values
`timescale 1ns / 1ps
`default_nettype none

module depth_pixel_reprojection (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire dpr_pkg::pixel_t                pixel,
  output logic                                done,
  output dpr_pkg::result_t                    result,
  input  wire logic                           cfg_we,
  input  wire logic [dpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dpr_pkg::*;

  logic [CFG_DATA_W-1:0] coef_uv [3];
  logic [CFG_DATA_W-1:0] coef_cb [3];
  logic [FRAME_W-1:0]    frame_width;
  logic [FRAME_W-1:0]    frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        coef_uv[r] <= '0;
        coef_cb[r] <= '0;
      end
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_X_UV:    coef_uv[0]   <= cfg_data;
        REG_COEF_X_CB:    coef_cb[0]   <= cfg_data;
        REG_COEF_Y_UV:    coef_uv[1]   <= cfg_data;
        REG_COEF_Y_CB:    coef_cb[1]   <= cfg_data;
        REG_COEF_Z_UV:    coef_uv[2]   <= cfg_data;
        REG_COEF_Z_CB:    coef_cb[2]   <= cfg_data;
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                  s1_vld, s2_vld, s3_vld, s4_vld;
  logic [DEPTH_BITS-1:0] s1_d, s2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
    end
    s1_d <= pixel.depth_mm;
    s2_d <= s1_d;
  end

  logic signed [SUM_W-1:0] sum [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [31:0]                cu, cv, cc, off;
    logic signed [32+COORD_BITS:0]     pu, pv;
    logic signed [34+COORD_BITS:0]     lin;
    logic signed [51+COORD_BITS:0]     prod;

    assign cu  = $signed(coef_uv[r][31:0]);
    assign cv  = $signed(coef_uv[r][63:32]);
    assign cc  = $signed(coef_cb[r][31:0]);
    assign off = $signed(coef_cb[r][63:32]);

    always_ff @(posedge clk) begin
      pu   <= cu * $signed({1'b0, pixel.src_col});
      pv   <= cv * $signed({1'b0, pixel.src_row});
      lin  <= (35+COORD_BITS)'(pu) + (35+COORD_BITS)'(pv) + (35+COORD_BITS)'(cc);
      prod <= lin * $signed({1'b0, s2_d});
      sum[r] <= SUM_W'(prod) + SUM_W'(off);
    end
  end

  logic signed [SUM_W-1:0] zlim;
  logic [SUM_W-1:0]        zdep;
  div_t                    din, dout;

  always_comb begin
    zlim = sum[2] <<< COORD_BITS;
    zdep = SUM_W'(sum[2] >>> COEF_FRAC_BITS);
    din.vld   = s4_vld;
    din.ok    = (sum[2] > 0) && (sum[0] >= 0) && (sum[1] >= 0)
                && (sum[2][SUM_W-2:SUM_W-1-COORD_BITS] != '0 || (sum[0] < zlim && sum[1] < zlim))
                && (zdep < SUM_W'(DEPTH_LIMIT));
    din.rx    = REM_W'(sum[0]);
    din.ry    = REM_W'(sum[1]);
    din.z     = sum[2][SUM_W-2:0];
    din.qx    = '0;
    din.qy    = '0;
    din.depth = zdep[DEPTH_BITS-1:0];
  end

  dpr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  logic fin_ok;

  assign fin_ok = dout.ok && ({1'b0, dout.qx} < frame_width)
                  && ({1'b0, dout.qy} < frame_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      result.valid_res <= 1'b0;
    end else begin
      done             <= dout.vld;
      result.valid_res <= dout.vld & fin_ok;
    end
    result.dest_col   <= fin_ok ? dout.qx : '0;
    result.dest_row   <= fin_ok ? dout.qy : '0;
    result.dest_depth <= fin_ok ? dout.depth : '0;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##TOTAL_LAT done)
    else $error("beat lost in pipeline");
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##TOTAL_LAT !done)
    else $error("unexpected beat");
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    result.valid_res |-> done)
    else $error("valid without strobe");
  a_depth_lim: assert property (@(posedge clk) disable iff (rst)
    result.valid_res |-> result.dest_depth < DEPTH_BITS'(DEPTH_LIMIT))
    else $error("depth over limit");
  a_zero_inv: assert property (@(posedge clk) disable iff (rst)
    (done && !result.valid_res) |-> (result.dest_col == '0 && result.dest_row == '0
      && result.dest_depth == '0))
    else $error("invalid beat not cleared");
`endif

endmodule

`default_nettype wire

// ===== design/dpr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpr_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dpr_pkg::div_t din,
  output dpr_pkg::div_t    dout
);
  import dpr_pkg::*;

  div_t st [DIV_LAT+1];

  assign st[0] = din;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [REM_W-1:0] dvs;
    div_t             nxt;

    always_comb begin
      dvs = REM_W'(st[k].z) << (DIV_LAT - 1 - k);
      nxt = st[k];
      if (st[k].rx >= dvs) begin
        nxt.rx = st[k].rx - dvs;
        nxt.qx[DIV_LAT-1-k] = 1'b1;
      end
      if (st[k].ry >= dvs) begin
        nxt.ry = st[k].ry - dvs;
        nxt.qy[DIV_LAT-1-k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1] <= '0;
      end else begin
        st[k+1] <= nxt;
      end
    end
  end

  assign dout = st[DIV_LAT];

endmodule

`default_nettype wire

// ===== verif/depth_pixel_reprojection_tb.sv =====
`timescale 1ns / 1ps

module depth_pixel_reprojection_tb;
  import dpr_pkg::*;

  localparam int SETTLE_CYCLES = TOTAL_LAT + 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 8;
  localparam int PIXELS_PER_PHASE = 50;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  class reproj_scoreboard;
    logic [CFG_DATA_W-1:0] coef[6];
    logic [FRAME_W-1:0] fw, fh;
    result_t pending_q[$];
    int errors;

    function new();
      foreach (coef[i]) coef[i] = '0;
      fw = WIDTH_RESET;
      fh = HEIGHT_RESET;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH: fw = v[FRAME_W-1:0];
        REG_FRAME_HEIGHT: fh = v[FRAME_W-1:0];
        default: coef[int'(idx)] = v;
      endcase
    endfunction

    function longint word_s(logic [31:0] w);
      return longint'(signed'(w));
    endfunction

    function longint row_sum(int r, longint u, longint v, longint d);
      longint lin;
      lin = word_s(coef[2*r][31:0]) * u + word_s(coef[2*r][63:32]) * v
          + word_s(coef[2*r+1][31:0]);
      return lin * d + word_s(coef[2*r+1][63:32]);
    endfunction

    function longint floor_quot(longint n, longint den);
      longint q;
      q = n / den;
      if ((n % den) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    function result_t predict(pixel_t p);
      longint xs, ys, zs, col, row, dep, wlim, hlim;
      result_t r;
      xs = row_sum(0, p.src_col, p.src_row, p.depth_mm);
      ys = row_sum(1, p.src_col, p.src_row, p.depth_mm);
      zs = row_sum(2, p.src_col, p.src_row, p.depth_mm);
      wlim = (fw < (1 << COORD_BITS)) ? fw : (1 << COORD_BITS);
      hlim = (fh < (1 << COORD_BITS)) ? fh : (1 << COORD_BITS);
      r = '0;
      if (zs > 0) begin
        col = floor_quot(xs, zs);
        row = floor_quot(ys, zs);
        dep = zs >>> COEF_FRAC_BITS;
        if (col >= 0 && col < wlim && row >= 0 && row < hlim && dep < DEPTH_LIMIT) begin
          r.dest_col = col[COORD_BITS-1:0];
          r.dest_row = row[COORD_BITS-1:0];
          r.dest_depth = dep[DEPTH_BITS-1:0];
          r.valid_res = 1'b1;
        end
      end
      return r;
    endfunction

    function void note_pixel(pixel_t p);
      pending_q.push_back(predict(p));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.dest_col !== want.dest_col) begin
        $display("%0t: dest_col exp %0d got %0d", $time, want.dest_col, got.dest_col);
        errors++;
      end
      if (got.dest_row !== want.dest_row) begin
        $display("%0t: dest_row exp %0d got %0d", $time, want.dest_row, got.dest_row);
        errors++;
      end
      if (got.dest_depth !== want.dest_depth) begin
        $display("%0t: dest_depth exp %0d got %0d", $time, want.dest_depth,
                 got.dest_depth);
        errors++;
      end
      if (got.valid_res !== want.valid_res) begin
        $display("%0t: valid_res exp %0b got %0b", $time, want.valid_res, got.valid_res);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, cfg_we;
  pixel_t pixel;
  result_t result;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  reproj_scoreboard sb = new();
  int stall_cnt = 0;
  int burst_left = 0;

  depth_pixel_reprojection i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_pixel(pixel);
      if (done) sb.check_result(result);
      if ((start && !busy) || done) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // drive one pixel, return at the edge that takes it with start still high
  task automatic send_pixel(pixel_t p);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  function automatic logic [63:0] pack2(logic [31:0] hi, logic [31:0] lo);
    return {hi, lo};
  endfunction

  function automatic logic [31:0] jitter(logic [31:0] base, int span);
    return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  task automatic apply_phase(int k);
    logic [31:0] zc;
    logic [11:0] w, h;
    zc = (k == 3) ? -ONE_Q16 : ONE_Q16;
    case (k)
      0, 3: begin w = 12'd1280; h = 12'd720; end
      1: begin w = 12'd4095; h = 12'd2048; end
      2: begin w = 12'd640; h = 12'd480; end
      4: begin w = 12'($urandom_range(1, 4095)); h = 12'($urandom_range(1, 4095)); end
      5: begin w = 12'd0; h = 12'd720; end
      6: begin w = 12'd1; h = 12'd1; end
      default: begin w = 12'd2048; h = 12'd4095; end
    endcase
    if (k == 4) begin
      write_reg(REG_COEF_X_UV, {$urandom, $urandom});
      write_reg(REG_COEF_X_CB, {$urandom, $urandom});
      write_reg(REG_COEF_Y_UV, {$urandom, $urandom});
      write_reg(REG_COEF_Y_CB, {$urandom, $urandom});
      write_reg(REG_COEF_Z_UV, {$urandom, $urandom});
      write_reg(REG_COEF_Z_CB, {$urandom, $urandom});
    end else if (k == 2 || k == 7) begin
      write_reg(REG_COEF_X_UV, pack2(jitter(0, 900), jitter(32'h8000, 900)));
      write_reg(REG_COEF_X_CB, pack2(jitter(32'h0100_0000, 1 << 20), jitter(0, 9000)));
      write_reg(REG_COEF_Y_UV, pack2(jitter(32'h8000, 900), jitter(0, 900)));
      write_reg(REG_COEF_Y_CB, pack2(-32'h0100_0000, jitter(-32'h0010_0000, 9000)));
      write_reg(REG_COEF_Z_UV, pack2(jitter(0, 3), jitter(0, 3)));
      write_reg(REG_COEF_Z_CB, pack2(jitter(0, 1 << 22), jitter(ONE_Q16, 4000)));
    end else begin
      write_reg(REG_COEF_X_UV, pack2(0, (k == 0) ? ONE_Q16 : jitter(ONE_Q16, 200)));
      write_reg(REG_COEF_X_CB, pack2(0, 0));
      write_reg(REG_COEF_Y_UV, pack2((k == 0) ? ONE_Q16 : jitter(ONE_Q16, 200), 0));
      write_reg(REG_COEF_Y_CB, pack2(0, 0));
      write_reg(REG_COEF_Z_UV, pack2(0, 0));
      write_reg(REG_COEF_Z_CB, pack2((k == 3) ? 32'h7fff_ffff : 0, zc));
    end
    write_reg(REG_FRAME_WIDTH, 64'(w));
    write_reg(REG_FRAME_HEIGHT, 64'(h));
    cfg_we <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.src_col = COORD_BITS'($urandom_range(0, 2047));
    p.src_row = COORD_BITS'($urandom_range(0, 2047));
    if ($urandom_range(0, 1) == 0) begin
      p.src_col = COORD_BITS'($urandom_range(0, 1300));
      p.src_row = COORD_BITS'($urandom_range(0, 740));
    end
    p.depth_mm = ($urandom_range(0, 2) == 0) ? DEPTH_BITS'($urandom)
                                             : DEPTH_BITS'($urandom_range(1, 39999));
    return p;
  endfunction

  initial begin
    pixel_t directed[$];
    rst = 1'b1;
    start = 1'b0;
    pixel = '0;
    cfg_we = 1'b0;
    cfg_index = REG_COEF_X_UV;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients give zero depth everywhere
    send_pixel('{11'd5, 11'd7, 16'd1000});
    send_pixel('{11'd2047, 11'd2047, 16'hffff});
    directed = '{
      '{11'd0, 11'd0, 16'd0}, '{11'd0, 11'd0, 16'd1}, '{11'd2047, 11'd2047, 16'hffff},
      '{11'd1279, 11'd719, 16'd39999}, '{11'd1280, 11'd10, 16'd500},
      '{11'd10, 11'd720, 16'd500}, '{11'd100, 11'd100, 16'd40000},
      '{11'd0, 11'd719, 16'd1}, '{11'd1279, 11'd0, 16'd20000},
      '{11'd1024, 11'd512, 16'd32768}, '{11'd2047, 11'd0, 16'd100},
      '{11'd0, 11'd2047, 16'd100}, '{11'd640, 11'd360, 16'hffff}
    };
    for (int k = 0; k < PHASES; k++) begin
      drain();
      apply_phase(k);
      @(posedge clk);
      if (k == 0 || k == 3 || k == 6) foreach (directed[i]) send_pixel(directed[i]);
      for (int i = 0; i < PIXELS_PER_PHASE; i++) send_pixel(rand_pixel());
    end
    drain();
    if (sb.pending_q.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
